FILE: sv/fcpi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the fan curve interpolator.
// Used by every module of the block; depends on nothing else.
package fcpi_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF     = 8;
    localparam int DUTY_BITS_DEF      = 8;
    localparam int TEMP_FRAC_BITS_DEF = 4;

    // Fixed field widths.
    localparam int TEMP_W     = 12;
    localparam int PCT_W      = 7;
    localparam int DUTY_W     = 8;
    localparam int PT_TEMP_W  = 8;
    localparam int CNT_W      = 4;
    localparam int TEMPS_W    = 64;
    localparam int PCTS_W     = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // The quotient of a segment interpolation never exceeds the percent delta.
    localparam int QUOT_W = PCT_W;

    // Largest duty width supported by the duty table.
    localparam int DUTY_TAB_W = 16;

    localparam int              PCT_SCALE = 100;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_PRESENT   = 3'd0,
        CFG_FALLBACK_PERCENT = 3'd1,
        CFG_POINT_COUNT      = 3'd2,
        CFG_CURVE_TEMPS      = 3'd3,
        CFG_CURVE_PERCENTS   = 3'd4
    } t_cfg_idx;

    // Configuration registers, grouped as they travel to the locate stage.
    typedef struct packed {
        logic               sensor_present;
        logic [PCT_W-1:0]   fallback_percent;
        logic [CNT_W-1:0]   point_count;
        logic [TEMPS_W-1:0] curve_temps;
        logic [PCTS_W-1:0]  curve_percents;
    } t_curve_cfg;

    localparam t_curve_cfg CFG_RESET = '{
        sensor_present:   1'b1,
        fallback_percent: 7'd100,
        point_count:      4'd5,
        curve_temps:      64'd258623742745,
        curve_percents:   56'd27012139520
    };

    // Duty value for every possible percent code.
    typedef logic [DUTY_TAB_W-1:0] t_duty_tab [2**PCT_W];

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Builds percent * (2^bits - 1) / 100, truncated, at elaboration.
    function automatic t_duty_tab f_duty_table(input int bits);
        t_duty_tab tab;
        for (int p = 0; p < 2**PCT_W; p++) begin
            tab[p] = DUTY_TAB_W'((p * ((1 << bits) - 1)) / PCT_SCALE);
        end
        return tab;
    endfunction

endpackage

FILE: sv/fcpi_locate.sv
`timescale 1ns / 1ps
// Segment search and operand setup: two pipeline stages.
// Depends on fcpi_pkg for field widths and the configuration struct.
module fcpi_locate import fcpi_pkg::*; #(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF,
    localparam int CW = f_max(TEMP_W, PT_TEMP_W + TEMP_FRAC_BITS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_curve_cfg               i_cfg,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CW-1:0]            o_dist,
    output logic [CW-1:0]            o_span,
    output logic signed [PCT_W:0]    o_pct_delta,
    output logic [PCT_W-1:0]         o_base_pct
);

    localparam int NSEG = MAX_POINTS - 1;

    // Point temperatures scaled to the sample's fixed point, and percentages.
    logic signed [CW-1:0] w_pt_temp [MAX_POINTS];
    logic [PCT_W-1:0]     w_pt_pct  [MAX_POINTS];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_pts
        assign w_pt_temp[g] =
            CW'(signed'(i_cfg.curve_temps[PT_TEMP_W*g +: PT_TEMP_W])) <<< TEMP_FRAC_BITS;
        assign w_pt_pct[g] = i_cfg.curve_percents[PCT_W*g +: PCT_W];
    end

    logic signed [CW-1:0] w_t;
    logic [CNT_W-1:0]     w_count;
    logic [MAX_POINTS-1:0] w_last_hot;
    logic signed [CW-1:0] w_t_last;
    logic [PCT_W-1:0]     w_pct_last;
    logic                 w_le_first;
    logic                 w_ge_last;
    logic [NSEG-1:0]      w_hit;
    logic [NSEG-1:0]      w_first_hit;
    logic                 w_direct;
    logic [PCT_W-1:0]     w_base;

    assign w_t     = CW'(i_temperature);
    assign w_count = (i_cfg.point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : i_cfg.point_count;

    // The last point in use, picked by a decoded count.
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_last
        assign w_last_hot[g] = (w_count == CNT_W'(g + 1));
    end

    always_comb begin
        w_t_last   = '0;
        w_pct_last = '0;
        for (int g = 0; g < MAX_POINTS; g++) begin
            if (w_last_hot[g]) begin
                w_t_last   = w_t_last | w_pt_temp[g];
                w_pct_last = w_pct_last | w_pt_pct[g];
            end
        end
    end

    assign w_le_first = (w_t <= w_pt_temp[0]);
    assign w_ge_last  = (w_t >= w_t_last);

    // A segment holds the sample when both of its points are in use and the sample lies between them.
    for (genvar g = 0; g < NSEG; g++) begin : g_seg
        assign w_hit[g] = (CNT_W'(g + 2) <= w_count) &&
                          (w_t >= w_pt_temp[g]) && (w_t < w_pt_temp[g + 1]);
    end

    // The lowest matching segment wins.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int g = 0; g < NSEG; g++) begin
            w_first_hit[g] = w_hit[g] && !seen;
            seen           = seen || w_hit[g];
        end
    end

    // Cases that bypass interpolation carry their percentage directly.
    always_comb begin
        w_direct = 1'b1;
        priority if (!i_cfg.sensor_present) begin
            w_base = i_cfg.fallback_percent;
        end else if (w_count == '0) begin
            w_base = '0;
        end else if (w_le_first) begin
            w_base = w_pt_pct[0];
        end else if (w_ge_last || !(|w_hit)) begin
            w_base = w_pct_last;
        end else begin
            w_direct = 1'b0;
            w_base   = w_pct_last;
        end
    end

    // Stall chain: a stage holds only when it is full and the next one holds.
    logic r1_valid;
    logic r2_valid;
    logic w_stall1;
    logic w_stall2;

    assign w_stall2 = r2_valid && i_stall;
    assign w_stall1 = r1_valid && w_stall2;
    assign o_stall  = w_stall1;
    assign o_valid  = r2_valid;

    // Stage 1: segment decision.
    logic                 r1_direct;
    logic [PCT_W-1:0]     r1_base;
    logic [NSEG-1:0]      r1_seg_hot;
    logic signed [CW-1:0] r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!w_stall1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall1) begin
            r1_direct  <= w_direct;
            r1_base    <= w_base;
            r1_seg_hot <= w_first_hit;
            r1_t       <= w_t;
        end
    end

    // Stage 2: offset, span and percent delta of the chosen segment.
    logic signed [CW-1:0] w_lo;
    logic signed [CW-1:0] w_hi;
    logic [PCT_W-1:0]     w_plo;
    logic [PCT_W-1:0]     w_phi;
    logic signed [CW:0]   w_span_full;
    logic signed [CW:0]   w_dist_full;

    always_comb begin
        w_lo  = '0;
        w_hi  = '0;
        w_plo = '0;
        w_phi = '0;
        for (int g = 0; g < NSEG; g++) begin
            if (r1_seg_hot[g]) begin
                w_lo  = w_lo | w_pt_temp[g];
                w_hi  = w_hi | w_pt_temp[g + 1];
                w_plo = w_plo | w_pt_pct[g];
                w_phi = w_phi | w_pt_pct[g + 1];
            end
        end
    end

    assign w_span_full = (CW + 1)'(w_hi) - (CW + 1)'(w_lo);
    assign w_dist_full = (CW + 1)'(r1_t) - (CW + 1)'(w_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (!w_stall2) begin
            r2_valid <= r1_valid;
        end
    end

    // A direct result divides zero by one so the quotient is zero.
    always_ff @(posedge i_clk) begin
        if (!w_stall2) begin
            if (r1_direct) begin
                o_dist      <= '0;
                o_span      <= CW'(1);
                o_pct_delta <= '0;
                o_base_pct  <= r1_base;
            end else begin
                o_dist      <= w_dist_full[CW-1:0];
                o_span      <= w_span_full[CW-1:0];
                o_pct_delta <= $signed({1'b0, w_phi}) - $signed({1'b0, w_plo});
                o_base_pct  <= w_plo;
            end
        end
    end

endmodule

FILE: sv/fcpi_floor_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on fcpi_pkg for the quotient width.
module fcpi_floor_div import fcpi_pkg::*; #(
    parameter int DEN_W = 16,
    parameter int SB_W  = PCT_W,
    localparam int NW   = DEN_W + QUOT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [NW-1:0]     i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic              i_neg,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_rem_nz,
    output logic              o_neg,
    output logic [SB_W-1:0]   o_sb
);

    localparam int LAST = QUOT_W - 1;

    // Stage registers; stage s resolves quotient bit LAST - s.
    logic              r_valid [QUOT_W];
    logic [NW-1:0]     r_rem   [QUOT_W];
    logic [QUOT_W-1:0] r_quot  [QUOT_W];
    logic [DEN_W-1:0]  r_den   [QUOT_W];
    logic              r_neg   [QUOT_W];
    logic [SB_W-1:0]   r_sb    [QUOT_W];

    logic              w_valid_in [QUOT_W];
    logic [NW-1:0]     w_rem_in   [QUOT_W];
    logic [QUOT_W-1:0] w_quot_in  [QUOT_W];
    logic [DEN_W-1:0]  w_den_in   [QUOT_W];
    logic              w_neg_in   [QUOT_W];
    logic [SB_W-1:0]   w_sb_in    [QUOT_W];
    logic              w_stall    [QUOT_W];
    logic              w_stall_nx [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
        localparam int K = LAST - s;

        logic [NW:0] w_sub;
        logic        w_bit;

        // Stage inputs come from the port or from the stage before.
        if (s == 0) begin : g_first
            assign w_valid_in[s] = i_valid;
            assign w_rem_in[s]   = i_num;
            assign w_quot_in[s]  = '0;
            assign w_den_in[s]   = i_den;
            assign w_neg_in[s]   = i_neg;
            assign w_sb_in[s]    = i_sb;
        end else begin : g_next
            assign w_valid_in[s] = r_valid[s - 1];
            assign w_rem_in[s]   = r_rem[s - 1];
            assign w_quot_in[s]  = r_quot[s - 1];
            assign w_den_in[s]   = r_den[s - 1];
            assign w_neg_in[s]   = r_neg[s - 1];
            assign w_sb_in[s]    = r_sb[s - 1];
        end

        if (s == LAST) begin : g_tail
            assign w_stall_nx[s] = i_stall;
        end else begin : g_body
            assign w_stall_nx[s] = w_stall[s + 1];
        end

        assign w_stall[s] = r_valid[s] && w_stall_nx[s];

        // Trial subtraction of the shifted divisor.
        assign w_sub = {1'b0, w_rem_in[s]} - ((NW + 1)'(w_den_in[s]) << K);
        assign w_bit = !w_sub[NW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (!w_stall[s]) begin
                r_valid[s] <= w_valid_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_stall[s]) begin
                r_rem[s]  <= w_bit ? w_sub[NW-1:0] : w_rem_in[s];
                r_quot[s] <= {w_quot_in[s][QUOT_W-2:0], w_bit};
                r_den[s]  <= w_den_in[s];
                r_neg[s]  <= w_neg_in[s];
                r_sb[s]   <= w_sb_in[s];
            end
        end
    end

    assign o_stall  = w_stall[0];
    assign o_valid  = r_valid[LAST];
    assign o_quot   = r_quot[LAST];
    assign o_rem_nz = |r_rem[LAST];
    assign o_neg    = r_neg[LAST];
    assign o_sb     = r_sb[LAST];

endmodule

FILE: sv/fcpi_duty.sv
`timescale 1ns / 1ps
// Floor correction, percent clamp and duty scaling: two pipeline stages.
// Depends on fcpi_pkg for widths and the duty table builder.
module fcpi_duty import fcpi_pkg::*; #(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [QUOT_W-1:0] i_quot,
    input  logic              i_rem_nz,
    input  logic              i_neg,
    input  logic [PCT_W-1:0]  i_base_pct,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PCT_W-1:0]  o_fan_percent,
    output logic [DUTY_W-1:0] o_duty_raw
);

    localparam t_duty_tab DUTY_TAB = f_duty_table(DUTY_BITS);

    logic ra_valid;
    logic rb_valid;
    logic w_stall_a;
    logic w_stall_b;

    assign w_stall_b = rb_valid && i_stall;
    assign w_stall_a = ra_valid && w_stall_b;
    assign o_stall   = w_stall_a;
    assign o_valid   = rb_valid;

    // A negative quotient with a remainder rounds one step further down.
    logic [QUOT_W:0]        w_mag;
    logic signed [PCT_W+1:0] w_q;
    logic signed [PCT_W+1:0] w_sum;
    logic [PCT_W-1:0]       w_pct;

    assign w_mag = {1'b0, i_quot} + (QUOT_W + 1)'(i_neg && i_rem_nz);
    assign w_q   = i_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w_sum = $signed({2'b00, i_base_pct}) + w_q;

    always_comb begin
        priority if (w_sum < 0) begin
            w_pct = '0;
        end else if (w_sum > $signed({2'b00, PCT_MAX})) begin
            w_pct = PCT_MAX;
        end else begin
            w_pct = w_sum[PCT_W-1:0];
        end
    end

    // Stage A: clamped percentage.
    logic [PCT_W-1:0] ra_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
        end else if (!w_stall_a) begin
            ra_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_a) begin
            ra_pct <= w_pct;
        end
    end

    // Stage B: output register with the duty lookup.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_valid <= 1'b0;
        end else if (!w_stall_b) begin
            rb_valid <= ra_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_b) begin
            o_fan_percent <= ra_pct;
            o_duty_raw    <= DUTY_TAB[ra_pct][DUTY_W-1:0];
        end
    end

endmodule

FILE: sv/fan_curve_pwm_interpolator.sv
`timescale 1ns / 1ps
// Fan curve interpolator: temperature sample in, fan percent and PWM duty out.
// An accepted beat passes through these pipeline stages to the output register:
// two locate stages, one multiply stage, seven divider stages and two duty stages.
// Takes one beat per cycle unless stalled; empty stages fill while the output is stalled.
// Synchronous active-low reset empties the pipeline and loads the default curve.
module fan_curve_pwm_interpolator import fcpi_pkg::*; #(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int DUTY_BITS      = DUTY_BITS_DEF,
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [TEMP_W-1:0] i_temperature,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PCT_W-1:0]         o_fan_percent,
    output logic [DUTY_W-1:0]        o_duty_raw
);

    localparam int CW = f_max(TEMP_W, PT_TEMP_W + TEMP_FRAC_BITS);
    localparam int NW = CW + QUOT_W;

    // Configuration registers.
    t_curve_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SENSOR_PRESENT:   r_cfg.sensor_present   <= i_cfg_data[0];
                CFG_FALLBACK_PERCENT: r_cfg.fallback_percent <= i_cfg_data[PCT_W-1:0];
                CFG_POINT_COUNT:      r_cfg.point_count      <= i_cfg_data[CNT_W-1:0];
                CFG_CURVE_TEMPS:      r_cfg.curve_temps      <= i_cfg_data[TEMPS_W-1:0];
                CFG_CURVE_PERCENTS:   r_cfg.curve_percents   <= i_cfg_data[PCTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Segment search and operand setup.
    logic                 w_loc_valid;
    logic                 w_loc_stall;
    logic [CW-1:0]        w_loc_dist;
    logic [CW-1:0]        w_loc_span;
    logic signed [PCT_W:0] w_loc_dp;
    logic [PCT_W-1:0]     w_loc_base;

    fcpi_locate #(
        .MAX_POINTS     (MAX_POINTS),
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_locate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .o_valid       (w_loc_valid),
        .i_stall       (w_loc_stall),
        .o_dist        (w_loc_dist),
        .o_span        (w_loc_span),
        .o_pct_delta   (w_loc_dp),
        .o_base_pct    (w_loc_base)
    );

    // Multiply stage: offset times the magnitude of the percent delta.
    logic             r3_valid;
    logic [NW-1:0]    r3_prod;
    logic [CW-1:0]    r3_span;
    logic             r3_neg;
    logic [PCT_W-1:0] r3_base;
    logic             w_div_stall;
    logic [PCT_W-1:0] w_dp_abs;

    assign w_loc_stall = r3_valid && w_div_stall;
    assign w_dp_abs    = w_loc_dp[PCT_W] ? PCT_W'(-w_loc_dp) : PCT_W'(w_loc_dp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (!w_loc_stall) begin
            r3_valid <= w_loc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_loc_stall) begin
            r3_prod <= NW'(w_loc_dist) * NW'(w_dp_abs);
            r3_span <= w_loc_span;
            r3_neg  <= w_loc_dp[PCT_W];
            r3_base <= w_loc_base;
        end
    end

    // Divider: magnitude quotient and remainder flag.
    logic              w_div_valid;
    logic              w_duty_stall;
    logic [QUOT_W-1:0] w_div_quot;
    logic              w_div_rem_nz;
    logic              w_div_neg;
    logic [PCT_W-1:0]  w_div_base;

    fcpi_floor_div #(
        .DEN_W (CW),
        .SB_W  (PCT_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r3_valid),
        .o_stall  (w_div_stall),
        .i_num    (r3_prod),
        .i_den    (r3_span),
        .i_neg    (r3_neg),
        .i_sb     (r3_base),
        .o_valid  (w_div_valid),
        .i_stall  (w_duty_stall),
        .o_quot   (w_div_quot),
        .o_rem_nz (w_div_rem_nz),
        .o_neg    (w_div_neg),
        .o_sb     (w_div_base)
    );

    // Floor correction, clamp and duty scaling.
    fcpi_duty #(
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_div_valid),
        .o_stall       (w_duty_stall),
        .i_quot        (w_div_quot),
        .i_rem_nz      (w_div_rem_nz),
        .i_neg         (w_div_neg),
        .i_base_pct    (w_div_base),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fan_percent (o_fan_percent),
        .o_duty_raw    (o_duty_raw)
    );

    // The divider must never see a zero divisor.
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> (r3_span != '0))
        else $error("zero divisor entered the divider");

    // Every delivered percentage lies in the clamped range.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fan_percent <= PCT_MAX))
        else $error("fan percent above limit");

    // Back-pressure upstream only when the output itself is full and held.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output");

endmodule
